>>> rtl/hecr_pkg.sv
// ----------------------------------------------------------------------------
// hecr_pkg
// shared widths and constants for the http event counter block
// ----------------------------------------------------------------------------
package hecr_pkg;

    localparam int TIME_W = 48;

    // scale doubled so that rounding becomes a floor of (2*d*1e6 + e) / (2*e)
    localparam int                SCALE_W     = 21;
    localparam logic [SCALE_W-1:0] RATE_SCALE2 = 21'd2000000;

    typedef enum logic [1:0] {
        CMD_REQ  = 2'd0,
        CMD_RESP = 2'd1,
        CMD_TIME = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    // counter classes, methods first then status digits
    localparam logic [3:0] CLS_GET   = 4'd0;
    localparam logic [3:0] CLS_POST  = 4'd1;
    localparam logic [3:0] CLS_HEAD  = 4'd2;
    localparam logic [3:0] CLS_PUT   = 4'd3;
    localparam logic [3:0] CLS_OTHER = 4'd4;
    localparam logic [3:0] CLS_1XX   = 4'd5;
    localparam logic [3:0] CLS_LAST  = 4'd9;
    localparam logic [3:0] CLS_NONE  = 4'd10;

endpackage

>>> rtl/http_event_counter_rates.sv
// ----------------------------------------------------------------------------
// http_event_counter_rates
// per-direction http method and status counters with per-second rates
// ----------------------------------------------------------------------------
// Items enter on the s-side stream (tuser carries cmd and direction) and one
// result beat leaves on the m-side stream for every item. Request and
// response beats bump at most one counter, read beats return a counter with its
// stored rate. A time sample past the minimum interval sweeps all twenty
// entries through one shared multiply/divide unit and snapshots them.
// Counters sit in one RAM, snapshots and rates in a second; both have a
// registered read, and the port reads, updates and writes back.
// A beat that hits a counter passes S_READ, then S_OUT registers its result;
// a beat that hits none, or a time sample that does not update, goes from
// acceptance straight to S_OUT. Input is taken only in S_IDLE, so a new item
// waits until the last one has left S_OUT. An updating time sample runs each
// entry through S_SREAD, S_SLOAD and S_SWAIT, where the rate unit does a
// bit-serial multiply and divide on NUM_W numerator bits: 54 at 32-bit counters.
// The min-interval register is written on the cfg channel, always ready.
// Reset clears the per-entry valid bits, so every counter, snapshot and
// rate reads as zero, the last update time returns to zero and the
// interval to 1000000 us. While the receiver stalls the result is held in
// the output register; one more item is taken and waits until it frees.
// ----------------------------------------------------------------------------
module http_event_counter_rates
    import hecr_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int RATE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cfg write: min_interval_us
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // s tdata: method_first_char, method_second_char, status_class_char,
    //          now_us, read_index, zero pad
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,
    // s tuser: cmd, direction
    input  logic [2:0]  i_s_tuser,
    // m tdata: counted_class, count_value, rate_value, zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,
    // m tuser: rates_updated
    output logic        o_m_tuser
);

    localparam int NUM_ENTRIES = 20;
    localparam int ADDR_W      = $clog2(NUM_ENTRIES);
    localparam int SM_W        = COUNT_BITS + RATE_BITS;

    localparam logic [3:0] DIR_STEP  = 4'd10;

    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_O    = 8'h4f;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_U    = 8'h55;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_FIVE = 8'h35;

    localparam logic [31:0] MIN_INTERVAL_RST = 32'd1000000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SREAD,
        S_SLOAD,
        S_SWAIT,
        S_OUT
    } t_state;

    // input unpacking
    t_cmd              in_cmd;
    logic              in_dir;
    logic [7:0]        in_c0;
    logic [7:0]        in_c1;
    logic [7:0]        in_st;
    logic [TIME_W-1:0] in_now;
    logic [3:0]        in_ridx;

    assign in_cmd  = t_cmd'(i_s_tuser[1:0]);
    assign in_dir  = i_s_tuser[2];
    assign in_c0   = i_s_tdata[7:0];
    assign in_c1   = i_s_tdata[15:8];
    assign in_st   = i_s_tdata[23:16];
    assign in_now  = i_s_tdata[71:24];
    assign in_ridx = i_s_tdata[75:72];

    t_state                r_state;
    logic [31:0]           r_min_interval;
    logic [TIME_W-1:0]     r_last;
    logic [TIME_W-1:0]     r_now;
    logic [TIME_W-1:0]     r_elapsed;
    logic [3:0]            r_cls;
    logic [ADDR_W-1:0]     r_idx;
    logic                  r_is_event;
    logic [ADDR_W-1:0]     r_k;
    logic [COUNT_BITS-1:0] r_ev;
    logic [2**ADDR_W-1:0]  r_cm_vld;
    logic [2**ADDR_W-1:0]  r_sm_vld;
    logic                  r_cm_hit;
    logic                  r_sm_hit;
    logic [3:0]            r_res_cls;
    logic [31:0]           r_res_cnt;
    logic [15:0]           r_res_rate;
    logic                  r_res_upd;
    logic                  r_m_valid;
    logic [55:0]           r_m_data;
    logic                  r_m_user;

    logic                  accept;
    logic [3:0]            acc_cls;
    logic [ADDR_W-1:0]     acc_idx;
    logic [TIME_W-1:0]     acc_elapsed;
    logic                  acc_update;

    logic [ADDR_W-1:0]     raddr;
    logic                  cm_we;
    logic [COUNT_BITS-1:0] cm_wdata;
    logic [COUNT_BITS-1:0] cm_rdata;
    logic                  sm_we;
    logic [SM_W-1:0]       sm_wdata;
    logic [SM_W-1:0]       sm_rdata;

    logic [COUNT_BITS-1:0] cur_cnt;
    logic [COUNT_BITS-1:0] cur_snap;
    logic [RATE_BITS-1:0]  cur_rate;
    logic [COUNT_BITS-1:0] upd_cnt;

    logic                  ru_start;
    logic                  ru_done;
    logic [RATE_BITS-1:0]  ru_rate;

    assign accept = i_s_tvalid && o_s_tready;

    // class decode
    always_comb begin
        acc_cls = CLS_NONE;
        unique case (in_cmd)
            CMD_REQ: begin
                priority if (in_c0 == CH_G)                    acc_cls = CLS_GET;
                else if (in_c0 == CH_P && in_c1 == CH_O)       acc_cls = CLS_POST;
                else if (in_c0 == CH_H)                        acc_cls = CLS_HEAD;
                else if (in_c0 == CH_P && in_c1 == CH_U)       acc_cls = CLS_PUT;
                else                                           acc_cls = CLS_OTHER;
            end
            CMD_RESP: begin
                if (in_st >= CH_ONE && in_st <= CH_FIVE) begin
                    acc_cls = CLS_1XX + 4'(in_st - CH_ONE);
                end
            end
            CMD_READ: begin
                if (in_ridx <= CLS_LAST) begin
                    acc_cls = in_ridx;
                end
            end
            CMD_TIME: acc_cls = CLS_NONE;
            default:  acc_cls = CLS_NONE;
        endcase
        acc_idx     = in_dir ? (ADDR_W'(acc_cls) + ADDR_W'(DIR_STEP)) : ADDR_W'(acc_cls);
        acc_elapsed = in_now - r_last;
        acc_update  = (in_now >= r_last) && (acc_elapsed != '0)
                   && (acc_elapsed >= TIME_W'(r_min_interval));
    end

    assign raddr = (r_state == S_IDLE) ? acc_idx : r_k;

    // invalid entries read as zero
    assign cur_cnt  = r_cm_hit ? cm_rdata : '0;
    assign cur_snap = r_sm_hit ? sm_rdata[COUNT_BITS-1:0] : '0;
    assign cur_rate = r_sm_hit ? sm_rdata[SM_W-1:COUNT_BITS] : '0;
    assign upd_cnt  = r_is_event ? (cur_cnt + 1'b1) : cur_cnt;

    assign cm_we    = (r_state == S_READ) && r_is_event;
    assign cm_wdata = upd_cnt;
    assign sm_we    = (r_state == S_SWAIT) && ru_done;
    assign sm_wdata = {ru_rate, r_ev};
    assign ru_start = (r_state == S_SLOAD);

    hecr_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_ENTRIES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (r_idx),
        .i_wdata (cm_wdata),
        .i_raddr (raddr),
        .o_rdata (cm_rdata)
    );

    hecr_ram #(
        .WIDTH (SM_W),
        .DEPTH (NUM_ENTRIES)
    ) u_snap_ram (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (r_k),
        .i_wdata (sm_wdata),
        .i_raddr (raddr),
        .o_rdata (sm_rdata)
    );

    hecr_rate_unit #(
        .COUNT_BITS (COUNT_BITS),
        .RATE_BITS  (RATE_BITS)
    ) u_rate_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ru_start),
        .i_delta   (cur_cnt - cur_snap),
        .i_elapsed (r_elapsed),
        .o_done    (ru_done),
        .o_rate    (ru_rate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_min_interval <= MIN_INTERVAL_RST;
            r_last         <= '0;
            r_cm_vld       <= '0;
            r_sm_vld       <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_min_interval <= i_cfg_data;
            end
            r_cm_hit <= r_cm_vld[raddr];
            r_sm_hit <= r_sm_vld[raddr];
            if (cm_we) begin
                r_cm_vld[r_idx] <= 1'b1;
            end
            if (sm_we) begin
                r_sm_vld[r_k] <= 1'b1;
            end
            if (r_state == S_OUT && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cls      <= acc_cls;
                        r_idx      <= acc_idx;
                        r_is_event <= (in_cmd == CMD_REQ) || (in_cmd == CMD_RESP);
                        r_now      <= in_now;
                        r_elapsed  <= acc_elapsed;
                        r_res_cls  <= CLS_NONE;
                        r_res_cnt  <= '0;
                        r_res_rate <= '0;
                        r_res_upd  <= 1'b0;
                        r_k        <= '0;
                        if (in_cmd == CMD_TIME) begin
                            r_state <= acc_update ? S_SREAD : S_OUT;
                        end else begin
                            r_state <= (acc_cls == CLS_NONE) ? S_OUT : S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_res_cls  <= r_cls;
                    r_res_cnt  <= 32'(upd_cnt);
                    r_res_rate <= 16'(cur_rate);
                    r_state    <= S_OUT;
                end
                S_SREAD: begin
                    r_state <= S_SLOAD;
                end
                S_SLOAD: begin
                    r_ev    <= cur_cnt;
                    r_state <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (ru_done) begin
                        if (r_k == ADDR_W'(NUM_ENTRIES - 1)) begin
                            r_last    <= r_now;
                            r_res_upd <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_SREAD;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_data  <= {4'd0, r_res_rate, r_res_cnt, r_res_cls};
                        r_m_user  <= r_res_upd;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tuser   = r_m_user;

endmodule

>>> rtl/hecr_ram.sv
// ----------------------------------------------------------------------------
// hecr_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module hecr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hecr_rate_unit.sv
// ----------------------------------------------------------------------------
// hecr_rate_unit
// shift-add multiply by 2e6, add of elapsed for rounding, then restoring divide, saturating rate result
// ----------------------------------------------------------------------------
module hecr_rate_unit
    import hecr_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int RATE_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_delta,
    input  logic [TIME_W-1:0]     i_elapsed,
    output logic                  o_done,
    output logic [RATE_BITS-1:0]  o_rate
);

    localparam int PROD_W  = COUNT_BITS + SCALE_W;
    localparam int NUM_W   = ((PROD_W > TIME_W + 1) ? PROD_W : TIME_W + 1) + 1;
    localparam int REM_W   = TIME_W + 2;
    localparam int DIV_W   = TIME_W + 1;
    localparam int Q_W     = RATE_BITS + 1;
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int MBIT_W  = $clog2(SCALE_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [NUM_W-1:0]      r_num;
    logic [REM_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_div;
    logic [Q_W-1:0]        r_q;
    logic [COUNT_BITS-1:0] r_delta;
    logic [TIME_W-1:0]     r_elapsed;
    logic [MBIT_W-1:0]     r_mbit;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [RATE_BITS-1:0]  r_rate;

    logic [REM_W-1:0] rem_sh;
    logic             q_bit;
    logic [Q_W-1:0]   n_q;
    logic [NUM_W-1:0] n_num_mul;

    always_comb begin
        rem_sh    = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
        q_bit     = (rem_sh >= REM_W'(r_div));
        // once above the limit the quotient stays pinned at limit + 1
        if (r_q[RATE_BITS] | r_q[RATE_BITS-1]) begin
            n_q = Q_W'(1) << RATE_BITS;
        end else begin
            n_q = {r_q[RATE_BITS-1:0], q_bit};
        end
        n_num_mul = {r_num[NUM_W-2:0], 1'b0}
                  + (RATE_SCALE2[r_mbit] ? NUM_W'(r_delta) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_DONE);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_delta   <= i_delta;
                        r_elapsed <= i_elapsed;
                        r_div     <= {i_elapsed, 1'b0};
                        r_num     <= '0;
                        r_mbit    <= MBIT_W'(SCALE_W - 1);
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num <= n_num_mul;
                    if (r_mbit == '0) begin
                        r_state <= S_ADD;
                    end else begin
                        r_mbit <= r_mbit - 1'b1;
                    end
                end
                S_ADD: begin
                    r_num   <= r_num + NUM_W'(r_elapsed);
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= CNT_W'(NUM_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= q_bit ? (rem_sh - REM_W'(r_div)) : rem_sh;
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_q   <= n_q;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    r_rate  <= r_q[RATE_BITS] ? '1 : r_q[RATE_BITS-1:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rate = r_rate;

endmodule
